### sv/lbrc_pkg.sv
// Package for the linear trace-buffer allocator.
// Holds the item structs, operation and status codes and the sequencer state type.
// Depends on nothing.
package lbrc_pkg;

   localparam int OP_W   = 2;
   localparam int CORE_W = 8;
   localparam int LEN_W  = 16;
   localparam int OFS_W  = 24;
   localparam int STAT_W = 4;
   localparam int TOT_W  = 32;
   localparam int CFG_W  = 24;

   localparam logic [OP_W-1:0] OP_OPEN    = 2'd0;
   localparam logic [OP_W-1:0] OP_RESERVE = 2'd1;
   localparam logic [OP_W-1:0] OP_COMMIT  = 2'd2;
   localparam logic [OP_W-1:0] OP_CLOSE   = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK          = 4'd0;
   localparam logic [STAT_W-1:0] ST_ZERO_LENGTH = 4'd1;
   localparam logic [STAT_W-1:0] ST_BAD_CORE    = 4'd2;
   localparam logic [STAT_W-1:0] ST_CLOSED      = 4'd3;
   localparam logic [STAT_W-1:0] ST_CORE_BUSY   = 4'd4;
   localparam logic [STAT_W-1:0] ST_FULL        = 4'd5;
   localparam logic [STAT_W-1:0] ST_NOT_PENDING = 4'd6;
   localparam logic [STAT_W-1:0] ST_BAD_RANGE   = 4'd7;
   localparam logic [STAT_W-1:0] ST_NOT_CLOSED  = 4'd8;

   localparam logic REG_BUFFER_BYTES = 1'b0;
   localparam logic [CFG_W-1:0] BUFFER_BYTES_RESET = 24'd65536;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [CORE_W-1:0] core_id;
      logic [LEN_W-1:0]  request_length;
      logic [OFS_W-1:0]  payload_offset;
      logic [LEN_W-1:0]  stored_length;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [OFS_W-1:0]  block_offset;
      logic              length_write;
      logic [OFS_W-1:0]  length_address;
      logic [LEN_W-1:0]  length_value;
      logic              length_invalid;
      logic [OFS_W-1:0]  published_offset;
      logic [TOT_W-1:0]  bytes_total;
   } rsp_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_EXEC,
      S_R_PREP,
      S_R_DIV,
      S_R_ALIGN,
      S_R_CHECK,
      S_R_BASE,
      S_R_END,
      S_R_CMP,
      S_C_CHECK,
      S_C_BLK,
      S_C_REQ,
      S_C_SUM,
      S_C_RNG,
      S_C_TOT,
      S_C_HDR,
      S_FINISH
   } state_type;

endpackage

### sv/lbrc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the per-core block end table; depends on nothing.
module lbrc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 8
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/linear_buffer_reserve_commit.sv
// Top level of the linear trace-buffer allocator: sequencer, shared adder and registers.
// Depends on lbrc_pkg and lbrc_ram.
//
// Channel  Ports                          Dir      Carries
// req      req_valid, req_stall, req_data  in      one command item
// rsp      rsp_valid, rsp_stall, rsp_data  out     one result item per command item
// csr      csr_psel .. csr_pready          in/out  buffer_bytes register
//
// Open and close pass through a single execute step before the result is loaded; commit
// and reserve run a chain of check and arithmetic steps; reserve rounds with the shared
// adder (word size minus one), a reciprocal multiplication and a scaling step, in order.
// After reset the buffer is closed, no core holds a block and buffer_bytes is 65536.
// A finished result waits in the output register while the next item is accepted; the
// sequencer only waits in its last step when that register is still full and stalled.
module linear_buffer_reserve_commit #(
   parameter int CORE_COUNT        = 8,
   parameter int LENGTH_WORD_BYTES = 4,
   parameter int OFFSET_BITS       = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  lbrc_pkg::req_type        req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output lbrc_pkg::rsp_type        rsp_data,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [2:0]               csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   localparam int OW   = (OFFSET_BITS < lbrc_pkg::OFS_W) ? OFFSET_BITS : lbrc_pkg::OFS_W;
   localparam int CIW  = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1;
   localparam int XW   = lbrc_pkg::LEN_W + 1;
   localparam int QS   = XW + 3;
   localparam int PW   = XW + QS;
   localparam int EW   = lbrc_pkg::OFS_W + 1;
   localparam int AW   = lbrc_pkg::TOT_W;
   localparam logic [AW-1:0] WORD    = AW'(LENGTH_WORD_BYTES);
   localparam logic [AW-1:0] WORD_M1 = AW'(LENGTH_WORD_BYTES - 1);
   localparam logic [XW-1:0] WORD_X  = XW'(LENGTH_WORD_BYTES);
   localparam logic [QS:0]   RECIP   = (QS + 1)'(((64'd1 << QS) + 64'(LENGTH_WORD_BYTES)
                                        - 64'd1) / 64'(LENGTH_WORD_BYTES));
   localparam logic [EW-1:0] OFF_MAX = EW'((64'd1 << OW) - 64'd1);
   localparam logic [CIW:0]  CORES   = (CIW + 1)'(CORE_COUNT);

   lbrc_pkg::state_type state_ff, state_in;
   lbrc_pkg::req_type   req_ff, req_in;
   lbrc_pkg::rsp_type   rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                closed_ff, closed_in;
   logic [OW-1:0]       ro_ff, ro_in;
   logic [OW-1:0]       hdr_ff, hdr_in;
   logic [AW-1:0]       total_ff, total_in;
   logic [CORE_COUNT-1:0] pend_ff, pend_in;
   logic [lbrc_pkg::CFG_W-1:0] buf_ff;
   logic [XW-1:0]       x_ff, x_in;
   logic [XW-1:0]       aln_ff, aln_in;
   logic [EW-1:0]       blk_ff, blk_in;
   logic [EW-1:0]       end_ff, end_in;
   logic [lbrc_pkg::OFS_W-1:0] addr_ff, addr_in;
   logic [lbrc_pkg::STAT_W-1:0] status_ff, status_in;

   logic [AW-1:0]       alu_a, alu_b;
   logic                alu_sub;
   logic [AW:0]         alu_res;
   logic                alu_borrow;

   logic [PW-1:0]       recip_prod;
   logic [XW-1:0]       quot;

   logic [CIW-1:0]      cidx;
   logic                bad_core;
   logic                ram_wr, ram_rd;
   logic [OW-1:0]       ram_rd_data;
   logic                csr_wr;
   logic                status_ok;

   assign alu_res    = {1'b0, alu_a} + (alu_sub ? ~{1'b0, alu_b} : {1'b0, alu_b})
                       + (AW + 1)'(alu_sub);
   assign alu_borrow = alu_res[AW];

   assign recip_prod = PW'(x_ff) * PW'(RECIP);
   assign quot       = recip_prod[PW-1:QS];

   assign cidx     = req_ff.core_id[CIW-1:0];
   assign bad_core = {1'b0, req_ff.core_id} >= (lbrc_pkg::CORE_W + 1)'(CORES);

   lbrc_ram #(
      .WIDTH (OW),
      .DEPTH (CORE_COUNT)
   ) u_end_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (cidx),
      .wr_data (end_ff[OW-1:0]),
      .rd_en   (ram_rd),
      .rd_addr (cidx),
      .rd_data (ram_rd_data)
   );

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[2] == lbrc_pkg::REG_BUFFER_BYTES);
   assign csr_prdata = (csr_paddr[2] == lbrc_pkg::REG_BUFFER_BYTES) ? 32'(buf_ff) : 32'd0;

   assign req_stall = (state_ff != lbrc_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign status_ok = (status_ff == lbrc_pkg::ST_OK);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      closed_in    = closed_ff;
      ro_in        = ro_ff;
      hdr_in       = hdr_ff;
      total_in     = total_ff;
      pend_in      = pend_ff;
      x_in         = x_ff;
      aln_in       = aln_ff;
      blk_in       = blk_ff;
      end_in       = end_ff;
      addr_in      = addr_ff;
      status_in    = status_ff;
      alu_a        = '0;
      alu_b        = '0;
      alu_sub      = 1'b0;
      ram_wr       = 1'b0;
      ram_rd       = 1'b0;
      case (state_ff)
         lbrc_pkg::S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               case (req_data.operation)
                  lbrc_pkg::OP_RESERVE: state_in = lbrc_pkg::S_R_PREP;
                  lbrc_pkg::OP_COMMIT:  state_in = lbrc_pkg::S_C_CHECK;
                  default:              state_in = lbrc_pkg::S_EXEC;
               endcase
            end
         end
         lbrc_pkg::S_EXEC: begin
            status_in = lbrc_pkg::ST_OK;
            if (req_ff.operation == lbrc_pkg::OP_OPEN) begin
               if (!closed_ff) begin
                  status_in = lbrc_pkg::ST_NOT_CLOSED;
               end else begin
                  closed_in = 1'b0;
                  ro_in     = '0;
                  hdr_in    = '0;
                  total_in  = '0;
               end
            end else begin
               closed_in = 1'b1;
            end
            state_in = lbrc_pkg::S_FINISH;
         end
         lbrc_pkg::S_R_PREP: begin
            alu_a    = AW'(req_ff.request_length);
            alu_b    = WORD_M1;
            x_in     = alu_res[XW-1:0];
            state_in = lbrc_pkg::S_R_DIV;
         end
         lbrc_pkg::S_R_DIV: begin
            x_in     = quot;
            state_in = lbrc_pkg::S_R_ALIGN;
         end
         lbrc_pkg::S_R_ALIGN: begin
            aln_in   = x_ff * WORD_X;
            state_in = lbrc_pkg::S_R_CHECK;
         end
         lbrc_pkg::S_R_CHECK: begin
            state_in = lbrc_pkg::S_FINISH;
            if (aln_ff == '0) begin
               status_in = lbrc_pkg::ST_ZERO_LENGTH;
            end else if (bad_core) begin
               status_in = lbrc_pkg::ST_BAD_CORE;
            end else if (closed_ff) begin
               status_in = lbrc_pkg::ST_CLOSED;
            end else if (pend_ff[cidx]) begin
               status_in = lbrc_pkg::ST_CORE_BUSY;
            end else begin
               state_in = lbrc_pkg::S_R_BASE;
            end
         end
         lbrc_pkg::S_R_BASE: begin
            alu_a    = AW'(ro_ff);
            alu_b    = WORD;
            blk_in   = alu_res[EW-1:0];
            addr_in  = lbrc_pkg::OFS_W'(ro_ff);
            state_in = lbrc_pkg::S_R_END;
         end
         lbrc_pkg::S_R_END: begin
            alu_a    = AW'(blk_ff);
            alu_b    = AW'(aln_ff);
            end_in   = alu_res[EW-1:0];
            state_in = lbrc_pkg::S_R_CMP;
         end
         lbrc_pkg::S_R_CMP: begin
            alu_a    = AW'(buf_ff);
            alu_b    = AW'(end_ff);
            alu_sub  = 1'b1;
            state_in = lbrc_pkg::S_FINISH;
            if (alu_borrow || aln_ff[XW-1] || (end_ff > OFF_MAX)) begin
               status_in = lbrc_pkg::ST_FULL;
            end else begin
               status_in     = lbrc_pkg::ST_OK;
               ro_in         = end_ff[OW-1:0];
               ram_wr        = 1'b1;
               pend_in[cidx] = 1'b1;
            end
         end
         lbrc_pkg::S_C_CHECK: begin
            ram_rd   = 1'b1;
            state_in = lbrc_pkg::S_FINISH;
            if (bad_core) begin
               status_in = lbrc_pkg::ST_BAD_CORE;
            end else if (closed_ff) begin
               status_in = lbrc_pkg::ST_CLOSED;
            end else if ((AW'(req_ff.payload_offset) < WORD) || (req_ff.stored_length == '0)) begin
               status_in = lbrc_pkg::ST_BAD_RANGE;
            end else begin
               state_in = lbrc_pkg::S_C_BLK;
            end
         end
         lbrc_pkg::S_C_BLK: begin
            alu_a    = AW'(req_ff.payload_offset);
            alu_b    = WORD;
            alu_sub  = 1'b1;
            blk_in   = alu_res[EW-1:0];
            addr_in  = alu_res[lbrc_pkg::OFS_W-1:0];
            state_in = lbrc_pkg::S_C_REQ;
         end
         lbrc_pkg::S_C_REQ: begin
            alu_a    = AW'(req_ff.stored_length);
            alu_b    = WORD;
            aln_in   = alu_res[XW-1:0];
            state_in = lbrc_pkg::S_C_SUM;
         end
         lbrc_pkg::S_C_SUM: begin
            alu_a    = AW'(blk_ff);
            alu_b    = AW'(aln_ff);
            end_in   = alu_res[EW-1:0];
            state_in = lbrc_pkg::S_C_RNG;
         end
         lbrc_pkg::S_C_RNG: begin
            alu_a    = AW'(ro_ff);
            alu_b    = AW'(end_ff);
            alu_sub  = 1'b1;
            state_in = lbrc_pkg::S_C_TOT;
            if (alu_borrow) begin
               status_in = lbrc_pkg::ST_BAD_RANGE;
               state_in  = lbrc_pkg::S_FINISH;
            end else if (!pend_ff[cidx]) begin
               status_in = lbrc_pkg::ST_NOT_PENDING;
               state_in  = lbrc_pkg::S_FINISH;
            end
         end
         lbrc_pkg::S_C_TOT: begin
            alu_a    = total_ff;
            alu_b    = AW'(aln_ff);
            total_in = alu_res[AW-1:0];
            state_in = lbrc_pkg::S_C_HDR;
         end
         lbrc_pkg::S_C_HDR: begin
            alu_a   = AW'(hdr_ff);
            alu_b   = AW'(ram_rd_data);
            alu_sub = 1'b1;
            if (alu_borrow) begin
               hdr_in = ram_rd_data;
            end
            pend_in[cidx] = 1'b0;
            status_in     = lbrc_pkg::ST_OK;
            state_in      = lbrc_pkg::S_FINISH;
         end
         lbrc_pkg::S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.status           = status_ff;
               rsp_in.block_offset     = '0;
               rsp_in.length_write     = 1'b0;
               rsp_in.length_address   = '0;
               rsp_in.length_value     = '0;
               rsp_in.length_invalid   = 1'b0;
               rsp_in.published_offset = lbrc_pkg::OFS_W'(hdr_ff);
               rsp_in.bytes_total      = total_ff;
               if (status_ok && (req_ff.operation == lbrc_pkg::OP_RESERVE)) begin
                  rsp_in.block_offset   = blk_ff[lbrc_pkg::OFS_W-1:0];
                  rsp_in.length_write   = 1'b1;
                  rsp_in.length_address = addr_ff;
                  rsp_in.length_value   = aln_ff[lbrc_pkg::LEN_W-1:0];
                  rsp_in.length_invalid = 1'b1;
               end else if (status_ok && (req_ff.operation == lbrc_pkg::OP_COMMIT)) begin
                  rsp_in.length_write   = 1'b1;
                  rsp_in.length_address = addr_ff;
                  rsp_in.length_value   = req_ff.stored_length;
               end
               rsp_valid_in = 1'b1;
               state_in     = lbrc_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = lbrc_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lbrc_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         closed_ff    <= 1'b1;
         ro_ff        <= '0;
         hdr_ff       <= '0;
         total_ff     <= '0;
         pend_ff      <= '0;
         buf_ff       <= lbrc_pkg::BUFFER_BYTES_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         closed_ff    <= closed_in;
         ro_ff        <= ro_in;
         hdr_ff       <= hdr_in;
         total_ff     <= total_in;
         pend_ff      <= pend_in;
         if (csr_wr) begin
            buf_ff <= csr_pwdata[lbrc_pkg::CFG_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      rsp_ff    <= rsp_in;
      x_ff      <= x_in;
      aln_ff    <= aln_in;
      blk_ff    <= blk_in;
      end_ff    <= end_in;
      addr_ff   <= addr_in;
      status_ff <= status_in;
   end

`ifndef SYNTHESIS
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("Sequencer took an item but did not go busy.");

   a_finish_loads_result : assert property (@(posedge clock) disable iff (reset)
      (state_ff == lbrc_pkg::S_FINISH && !(rsp_valid_ff && rsp_stall)) |=>
      (rsp_valid && state_ff == lbrc_pkg::S_IDLE))
      else $error("Finished item did not reach the output register.");

   a_write_only_on_success : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.length_write) |-> (rsp_data.status == lbrc_pkg::ST_OK))
      else $error("Length word write requested on a failed item.");
`endif

endmodule
